FILE: src/gwcc_pkg.sv
// shared types and constants for the grid window collision check unit
// no dependencies; imported by every module of the unit
`default_nettype none

package gwcc_pkg;

  // doubled map coordinates, signed
  localparam int COORD_W = 13;

  // widths of fixed payload fields
  localparam int CELL_W  = 8;
  localparam int POS_W   = 10;
  localparam int INFL_W  = 4;
  localparam int DIMR_W  = 9;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INFLATION  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd3;

  // request modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // one grid access entering the address pipeline
  typedef struct packed {
    logic                      vld;
    logic                      wr;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [CELL_W-1:0]         data;
  } gwcc_elem_t;

  // memory operation, already qualified by the in-map check
  typedef struct packed {
    logic rd;
    logic wr;
  } gwcc_memop_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ISSUE  = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } gwcc_state_t;

endpackage

`default_nettype wire

FILE: src/gwcc_grid_mem.sv
// occupancy grid storage: one synchronous write/read port, registered read data
// depends on gwcc_pkg
`default_nettype none

module gwcc_grid_mem
  import gwcc_pkg::*;
#(
  parameter int MAX_MAP_DIM = 256
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire gwcc_memop_t                                  op,
  input  wire logic [$clog2(MAX_MAP_DIM*MAX_MAP_DIM)-1:0]   addr,
  input  wire logic [CELL_W-1:0]                            wdata,
  output logic                                              rd_vld,
  output logic [CELL_W-1:0]                                 rd_data
);

  localparam int DEPTH = MAX_MAP_DIM * MAX_MAP_DIM;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[addr] <= wdata;
    end
    if (op.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= op.rd;
    end
  end

  assign rd_vld  = rd_vld_r;
  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: src/gwcc_addr_pipe.sv
// address pipeline: in-map check on doubled coordinates, row times width, add column
// depends on gwcc_pkg
`default_nettype none

module gwcc_addr_pipe
  import gwcc_pkg::*;
#(
  parameter int MAX_MAP_DIM = 256
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire gwcc_elem_t                                   elem,
  input  wire logic [$clog2(MAX_MAP_DIM+1)-1:0]             w_dim,
  input  wire logic [$clog2(MAX_MAP_DIM+1)-1:0]             h_dim,
  output logic                                              busy,
  output gwcc_memop_t                                       op,
  output logic [$clog2(MAX_MAP_DIM*MAX_MAP_DIM)-1:0]        addr,
  output logic [CELL_W-1:0]                                 wdata
);

  localparam int DW = $clog2(MAX_MAP_DIM + 1);
  localparam int IW = $clog2(MAX_MAP_DIM);
  localparam int AW = $clog2(MAX_MAP_DIM * MAX_MAP_DIM);

  logic signed [COORD_W-1:0] w2;
  logic signed [COORD_W-1:0] h2;
  logic                      in_map;

  logic              s1_vld_r;
  logic              s1_wr_r;
  logic              s1_in_r;
  logic [IW-1:0]     s1_row_r;
  logic [IW-1:0]     s1_col_r;
  logic [CELL_W-1:0] s1_data_r;

  logic [IW+DW-1:0]  prod;

  logic              s2_vld_r;
  logic              s2_wr_r;
  logic              s2_in_r;
  logic [AW-1:0]     s2_prod_r;
  logic [IW-1:0]     s2_col_r;
  logic [CELL_W-1:0] s2_data_r;

  // doubled dimensions
  assign w2 = $signed({{(COORD_W-DW-1){1'b0}}, w_dim, 1'b0});
  assign h2 = $signed({{(COORD_W-DW-1){1'b0}}, h_dim, 1'b0});

  assign in_map = !elem.dx[COORD_W-1] && (elem.dx < w2) &&
                  !elem.dy[COORD_W-1] && (elem.dy < h2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= elem.vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  // halving a non-negative doubled coordinate is a shift
  always_ff @(posedge clk) begin
    s1_wr_r   <= elem.wr;
    s1_in_r   <= in_map;
    s1_row_r  <= elem.dy[IW:1];
    s1_col_r  <= elem.dx[IW:1];
    s1_data_r <= elem.data;
  end

  assign prod = s1_row_r * w_dim;

  always_ff @(posedge clk) begin
    s2_wr_r   <= s1_wr_r;
    s2_in_r   <= s1_in_r;
    s2_prod_r <= prod[AW-1:0];
    s2_col_r  <= s1_col_r;
    s2_data_r <= s1_data_r;
  end

  assign addr  = s2_prod_r + AW'(s2_col_r);
  assign wdata = s2_data_r;
  assign op.wr = s2_vld_r && s2_wr_r && s2_in_r;
  assign op.rd = s2_vld_r && !s2_wr_r && s2_in_r;
  assign busy  = s1_vld_r || s2_vld_r;

endmodule

`default_nettype wire

FILE: src/grid_window_collision_check_unit.sv
// grid window collision check unit on gwcc_pkg, gwcc_addr_pipe and gwcc_grid_mem: a write
// request stores one grid cell, a query scans an n by n window (n = window side, capped)
// a query gives its result after the window scan and the address pipeline drain; writes give none
// throughput: one request at a time, one grid cell read a cycle; a query holds the input until
// its result is loaded (longer while the result register is full), a write until its access drains
// reset (rst_n, synchronous, active low) clears control and loads register defaults only
`default_nettype none

module grid_window_collision_check_unit
  import gwcc_pkg::*;
#(
  parameter int MAX_MAP_DIM   = 256,
  parameter int MAX_INFLATION = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,   // cell_x[9:0], cell_y[19:10], cell_value[27:20]
  input  wire logic [0:0]           in_tuser,   // mode[0]
  // result channel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_tdata,  // collision[0]
  // register write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIMR_W-1:0]    cfg_data
);

  localparam int DW = $clog2(MAX_MAP_DIM + 1);
  localparam int AW = $clog2(MAX_MAP_DIM * MAX_MAP_DIM);

  // configuration registers
  logic [DIMR_W-1:0]        map_width_r;
  logic [DIMR_W-1:0]        map_height_r;
  logic [INFL_W-1:0]        inflation_r;
  logic signed [CELL_W-1:0] threshold_r;

  // effective (saturated) settings
  logic [DW-1:0]            w_dim;
  logic [DW-1:0]            h_dim;
  logic [INFL_W-1:0]        n_cfg;

  // request control
  gwcc_state_t              state_r, state_nxt;
  logic                     wr_r, wr_nxt;
  logic signed [POS_W-1:0]  x_r, x_nxt;
  logic signed [POS_W-1:0]  y_r, y_nxt;
  logic [CELL_W-1:0]        val_r, val_nxt;
  logic [INFL_W-1:0]        n_r, n_nxt;
  logic [INFL_W-1:0]        i_r, i_nxt;
  logic [INFL_W-1:0]        j_r, j_nxt;
  logic                     hit_r, hit_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_coll_r, out_coll_nxt;

  logic                     in_acc;
  logic                     last_elem;
  logic [COORD_W-1:0]       off;
  gwcc_elem_t               elem;
  gwcc_memop_t              op;
  logic [AW-1:0]            addr;
  logic [CELL_W-1:0]        wdata;
  logic                     busy;
  logic                     rd_vld;
  logic [CELL_W-1:0]        rd_data;
  logic signed [CELL_W-1:0] rd_val;

  // ---------------------------------------------------------------------------
  // register port, always ready; the user, not the block, must see that it is written only while the unit is idle
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
      inflation_r  <= 4'd5;
      threshold_r  <= 8'sd50;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_data;
        CFG_MAP_HEIGHT: map_height_r <= cfg_data;
        CFG_INFLATION:  inflation_r  <= cfg_data[INFL_W-1:0];
        CFG_THRESHOLD:  threshold_r  <= cfg_data[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // dimensions above the grid size saturate; the window side saturates too
  assign w_dim = (32'(map_width_r) > MAX_MAP_DIM)  ? DW'(MAX_MAP_DIM) : DW'(map_width_r);
  assign h_dim = (32'(map_height_r) > MAX_MAP_DIM) ? DW'(MAX_MAP_DIM) : DW'(map_height_r);
  assign n_cfg = (32'(inflation_r) > MAX_INFLATION) ? INFL_W'(MAX_INFLATION) : inflation_r;

  // ---------------------------------------------------------------------------
  // window sequencer
  //   idle   -> issue  : request accepted (a query with an empty window goes to drain)
  //   issue            : one grid access a cycle, a write issues exactly one
  //   drain            : wait until the address pipeline is empty
  //   finish           : a write goes back to idle; a query result goes into the output register once it is free
  // ---------------------------------------------------------------------------
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign last_elem = wr_r || ((i_r == n_r - 4'd1) && (j_r == n_r - 4'd1));

  // stored cell value as a signed number
  assign rd_val = $signed(rd_data);

  always_comb begin
    state_nxt     = state_r;
    wr_nxt        = wr_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    val_nxt       = val_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_coll_nxt  = out_coll_r;

    // any in-map cell above threshold or unknown (negative) is a hit
    if (rd_vld && ((rd_val > threshold_r) || rd_val[CELL_W-1])) begin
      hit_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          wr_nxt  = (in_tuser[0] == MODE_WRITE);
          x_nxt   = $signed(in_tdata[9:0]);
          y_nxt   = $signed(in_tdata[19:10]);
          val_nxt = in_tdata[27:20];
          n_nxt   = n_cfg;
          i_nxt   = '0;
          j_nxt   = '0;
          hit_nxt = 1'b0;
          if (in_tuser[0] == MODE_QUERY && n_cfg == '0) begin
            state_nxt = ST_DRAIN;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        if (last_elem) begin
          state_nxt = ST_DRAIN;
        end else if (j_r == n_r - 4'd1) begin
          j_nxt = '0;
          i_nxt = i_r + 4'd1;
        end else begin
          j_nxt = j_r + 4'd1;
        end
      end
      ST_DRAIN: begin
        // the last read lands in hit_r at this edge at the latest
        if (!busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (wr_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_coll_nxt  = hit_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_r       <= wr_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    val_r      <= val_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    out_coll_r <= out_coll_nxt;
  end

  // doubled window coordinates: 2x + 2i - n, the corner half a window below the query
  // cell; a write uses the cell itself (no offset, single element)
  assign off       = wr_r ? '0 : {{(COORD_W-INFL_W){1'b0}}, n_r};
  assign elem.vld  = (state_r == ST_ISSUE);
  assign elem.wr   = wr_r;
  assign elem.dx   = $signed({{2{x_r[POS_W-1]}}, x_r, 1'b0}
                   + {{(COORD_W-INFL_W-1){1'b0}}, i_r, 1'b0} - off);
  assign elem.dy   = $signed({{2{y_r[POS_W-1]}}, y_r, 1'b0}
                   + {{(COORD_W-INFL_W-1){1'b0}}, j_r, 1'b0} - off);
  assign elem.data = val_r;

  gwcc_addr_pipe #(
    .MAX_MAP_DIM(MAX_MAP_DIM)
  ) u_addr_pipe (
    .clk   (clk),
    .rst_n (rst_n),
    .elem  (elem),
    .w_dim (w_dim),
    .h_dim (h_dim),
    .busy  (busy),
    .op    (op),
    .addr  (addr),
    .wdata (wdata)
  );

  gwcc_grid_mem #(
    .MAX_MAP_DIM(MAX_MAP_DIM)
  ) u_grid_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (op),
    .addr    (addr),
    .wdata   (wdata),
    .rd_vld  (rd_vld),
    .rd_data (rd_data)
  );

  // result register
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_coll_r};

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!busy && !rd_vld))
    else $error("request accepted with grid accesses still in flight");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld |-> ((state_r == ST_ISSUE) || (state_r == ST_DRAIN)))
    else $error("grid read returned outside a window scan");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ISSUE) && !wr_r) |-> ((i_r < n_r) && (j_r < n_r)))
    else $error("window counters beyond the window side");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r == ST_FINISH) && !$past(wr_r)))
    else $error("result produced without a finished query");

endmodule

`default_nettype wire
